FILE: rtl/ftfb_pkg.sv
// shared types, codes and helpers for the fragment texture, fog and blend pipeline
package ftfb_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_FLAGS   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_COMBINE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CONST   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TINT    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FOG_END = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_FOG_INV = 3'd5;

	localparam logic [1:0] OP_PASS     = 2'd0;
	localparam logic [1:0] OP_MODULATE = 2'd1;
	localparam logic [1:0] OP_ADD      = 2'd2;

	localparam logic [1:0] OUT_WRITTEN   = 2'd0;
	localparam logic [1:0] OUT_UNCOVERED = 2'd1;
	localparam logic [1:0] OUT_DEPTH     = 2'd2;
	localparam logic [1:0] OUT_ALPHA     = 2'd3;

	localparam logic [7:0] ALPHA_MIN = 8'd4;

	typedef struct packed {
		logic        covered;
		logic [31:0] texel_00;
		logic [31:0] texel_01;
		logic [31:0] texel_10;
		logic [31:0] texel_11;
		logic [7:0]  frac_u;
		logic [7:0]  frac_v;
		logic [31:0] vertex_color;
		logic [23:0] frag_depth;
		logic [23:0] stored_depth;
		logic [31:0] dest_color;
		logic signed [23:0] fog_distance;
	} frag_t;

	typedef struct packed {
		logic        color_write;
		logic [31:0] color_out;
		logic        depth_write;
		logic [23:0] depth_out;
		logic [1:0]  outcome;
	} result_t;

	typedef struct packed {
		logic [7:0]  flags;
		logic [1:0]  combine_op;
		logic [31:0] constant_factor;
		logic [31:0] fog_tint;
		logic signed [23:0] fog_end;
		logic [23:0] fog_inv_range;
	} cfg_t;

	// per channel (a*(256-f) + b*f) >> 8, f in 0..256
	function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
			input logic [8:0] f);
		logic [17:0] s;
		s = 18'(a) * 18'(9'd256 - f) + 18'(b) * 18'(f);
		return s[15:8];
	endfunction

	function automatic logic [31:0] lerp_argb(input logic [31:0] a, input logic [31:0] b,
			input logic [8:0] f);
		logic [31:0] r;
		for (int i = 0; i < 4; i++)
			r[i*8 +: 8] = lerp8(a[i*8 +: 8], b[i*8 +: 8], f);
		return r;
	endfunction

endpackage

FILE: rtl/ftfb_if.sv
// valid/ready channel carrying one payload
interface ftfb_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ftfb_cfg_if.sv
// configuration write channel
interface ftfb_cfg_if import ftfb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [31:0]        wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/fragment_texture_fog_blend.sv
// top level of the fragment texture, fog and blend pipeline
//  channel   dir  payload        transaction
//  frag      in   frag_t         frag.valid & frag.ready
//  result    out  result_t       result.valid & result.ready
//  cfg       in   index, wdata   cfg.valid & cfg.ready (always ready)
// six register stages, one fragment per cycle while the output is not stalled.
// the whole pipe advances when the output register is empty or taken;
// a stall freezes every stage so nothing is lost or repeated.
// reset clears configuration and stage valid bits.
module fragment_texture_fog_blend import ftfb_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	ftfb_if.sink   frag,
	ftfb_if.source result,
	ftfb_cfg_if.sink cfg
);
	cfg_t regs;
	logic en;

	ftfb_regs u_regs (.clk(clk), .arst_n(arst_n), .cfg(cfg), .regs(regs));

	assign en = !result.valid || result.ready;
	assign frag.ready = en;

	ftfb_pipe u_pipe (
		.clk(clk), .arst_n(arst_n), .regs(regs), .en(en),
		.in_valid(frag.valid), .in_frag(frag.data),
		.out_valid(result.valid), .out_res(result.data)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.data))
		else $error("result changed under stall");
	a_write_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.color_write == (result.data.outcome == OUT_WRITTEN)))
		else $error("colour write disagrees with outcome");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.depth_write |-> result.data.color_write)
		else $error("depth write on rejected fragment");
endmodule

FILE: rtl/ftfb_regs.sv
// configuration register file
module ftfb_regs import ftfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ftfb_cfg_if.sink   cfg,
	output cfg_t       regs
);
	cfg_t regs_q;
	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FLAGS:   regs_q.flags <= cfg.wdata[7:0];
				REG_COMBINE: regs_q.combine_op <= cfg.wdata[1:0];
				REG_CONST:   regs_q.constant_factor <= cfg.wdata;
				REG_TINT:    regs_q.fog_tint <= cfg.wdata;
				REG_FOG_END: regs_q.fog_end <= cfg.wdata[23:0];
				REG_FOG_INV: regs_q.fog_inv_range <= cfg.wdata[23:0];
				default: ;
			endcase
		end
	end
endmodule

FILE: rtl/ftfb_pipe.sv
// six stage datapath: filter, combine, fog product, fog scale, fog mix, blend
module ftfb_pipe import ftfb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    regs,
	input  logic    en,
	input  logic    in_valid,
	input  frag_t   in_frag,
	output logic    out_valid,
	output result_t out_res
);
	// stage 1: horizontal lerps, depth test, fog difference
	logic [31:0] h0_s1, h1_s1, diffuse_s1, dst_s1;
	logic [7:0]  fv_s1;
	logic [23:0] zf_s1;
	logic [1:0]  rej_s1;
	logic        v_s1;
	logic signed [24:0] diff_s1;

	logic [1:0] rej_c;
	always_comb begin
		priority if (!in_frag.covered) rej_c = OUT_UNCOVERED;
		else if (regs.flags[4] && regs.flags[5] && in_frag.frag_depth > in_frag.stored_depth)
			rej_c = OUT_DEPTH;
		else rej_c = OUT_WRITTEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (!(regs.flags[0] && regs.flags[1]))
				h0_s1 <= in_frag.texel_00;
			else
				h0_s1 <= lerp_argb(in_frag.texel_00, in_frag.texel_01, {1'b0, in_frag.frac_u});
			h1_s1 <= lerp_argb(in_frag.texel_10, in_frag.texel_11, {1'b0, in_frag.frac_u});
			fv_s1 <= in_frag.frac_v;
			diffuse_s1 <= in_frag.vertex_color;
			dst_s1 <= in_frag.dest_color;
			zf_s1 <= in_frag.frag_depth;
			rej_s1 <= rej_c;
			diff_s1 <= 25'(regs.fog_end) - 25'(in_frag.fog_distance);
		end
	end

	// stage 2: vertical lerp, texel select
	logic [31:0] arg1_s2, diffuse_s2, dst_s2;
	logic [23:0] zf_s2;
	logic [1:0]  rej_s2;
	logic        v_s2;
	logic signed [24:0] diff_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (!regs.flags[0]) arg1_s2 <= diffuse_s1;
			else if (regs.flags[1]) arg1_s2 <= lerp_argb(h0_s1, h1_s1, {1'b0, fv_s1});
			else arg1_s2 <= h0_s1;
			diffuse_s2 <= diffuse_s1;
			dst_s2 <= dst_s1;
			zf_s2 <= zf_s1;
			rej_s2 <= rej_s1;
			diff_s2 <= diff_s1;
		end
	end

	// stage 3: colour combine, fog product
	logic [31:0] frag_s3, dst_s3;
	logic [23:0] zf_s3;
	logic [1:0]  rej_s3;
	logic        v_s3, fog_pos_s3;
	logic [47:0] p_s3;
	logic [31:0] arg2_c, comb_c;
	logic [8:0]  sum_c;
	logic [15:0] prod_c;
	always_comb begin
		arg2_c = regs.flags[2] ? diffuse_s2 : regs.constant_factor;
		comb_c = arg1_s2;
		for (int i = 0; i < 4; i++) begin
			prod_c = 16'(arg1_s2[i*8 +: 8]) * 16'(arg2_c[i*8 +: 8]);
			sum_c = 9'(arg1_s2[i*8 +: 8]) + 9'(arg2_c[i*8 +: 8]);
			if (regs.combine_op == OP_MODULATE || (regs.combine_op == OP_ADD && i == 3))
				comb_c[i*8 +: 8] = prod_c[15:8];
			else if (regs.combine_op == OP_ADD)
				comb_c[i*8 +: 8] = sum_c[8] ? 8'hFF : sum_c[7:0];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			frag_s3 <= comb_c;
			dst_s3 <= dst_s2;
			zf_s3 <= zf_s2;
			rej_s3 <= rej_s2;
			fog_pos_s3 <= diff_s2 > 25'sd0;
			p_s3 <= 48'(diff_s2[23:0]) * 48'(regs.fog_inv_range);
		end
	end

	// stage 4: fog coefficient, alpha discard
	logic [31:0] frag_s4, dst_s4;
	logic [23:0] zf_s4;
	logic [1:0]  rej_s4;
	logic        v_s4;
	logic [8:0]  f_s4;
	logic [39:0] sc_c;
	logic [7:0]  scaled_c, t_c;
	always_comb begin
		sc_c = 40'(p_s3[31:0]) * 40'd255;
		if (!fog_pos_s3) scaled_c = 8'd0;
		else if (p_s3[47:32] != '0) scaled_c = 8'd255;
		else scaled_c = sc_c[39:32];
		t_c = 8'd255 - scaled_c;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			frag_s4 <= frag_s3;
			dst_s4 <= dst_s3;
			zf_s4 <= zf_s3;
			rej_s4 <= (rej_s3 == OUT_WRITTEN && frag_s3[31:24] < ALPHA_MIN) ? OUT_ALPHA : rej_s3;
			f_s4 <= 9'(t_c) + 9'(t_c[7]);
		end
	end

	// stage 5: fog mix
	logic [31:0] frag_s5, dst_s5;
	logic [23:0] zf_s5;
	logic [1:0]  rej_s5;
	logic        v_s5;
	logic [31:0] fog_c;
	assign fog_c = lerp_argb(frag_s4, regs.fog_tint, f_s4);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (regs.flags[3])
				frag_s5 <= {frag_s4[31:24], fog_c[23:0]};
			else
				frag_s5 <= frag_s4;
			dst_s5 <= dst_s4;
			zf_s5 <= zf_s4;
			rej_s5 <= rej_s4;
		end
	end

	// stage 6: alpha blend and result
	result_t res_c;
	logic [7:0]  sa_c, df_c;
	logic [16:0] bl_c;
	always_comb begin
		sa_c = frag_s5[31:24];
		df_c = regs.flags[7] ? 8'd255 - sa_c : 8'd255;
		res_c = '0;
		bl_c = '0;
		res_c.outcome = rej_s5;
		if (rej_s5 == OUT_WRITTEN) begin
			res_c.color_write = 1'b1;
			res_c.color_out[31:24] = sa_c;
			for (int i = 0; i < 3; i++) begin
				bl_c = 17'(frag_s5[i*8 +: 8]) * 17'(sa_c) + 17'(dst_s5[i*8 +: 8]) * 17'(df_c)
					+ 17'd128;
				res_c.color_out[i*8 +: 8] = (bl_c[16] != 1'b0) ? 8'hFF : bl_c[15:8];
			end
			if (regs.flags[4] && regs.flags[6]) begin
				res_c.depth_write = 1'b1;
				res_c.depth_out = zf_s5;
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) out_res <= res_c;
	end
endmodule
